FILE: hw/rtl/dpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, constants and calendar tables for the date pair
// day difference block. No dependencies.
package dpd_pkg;

   // Field widths
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int SERIAL_W = 23;
   localparam int DIFF_W   = 23;
   localparam int DBM_W    = 9;

   // Divide by 100 through a reciprocal multiply: q = (x * 5243) >> 19,
   // exact for every 14-bit x
   localparam int DIV100_MUL = 5243;
   localparam int MUL_W      = 13;
   localparam int PROD_W     = YEAR_W + MUL_W;
   localparam int QUOT_W     = 8;

   // Calendar constants
   localparam int DAYS_PER_YEAR = 365;
   localparam int CENTURY       = 100;
   localparam int MONTH_FEB     = 2;
   localparam int MONTH_APR     = 4;
   localparam int MONTH_JUN     = 6;
   localparam int MONTH_SEP     = 9;
   localparam int MONTH_NOV     = 11;
   localparam int MONTH_DEC     = 12;

   // Saturation bounds of the difference
   localparam logic signed [DIFF_W-1:0] DIFF_MAX = {1'b0, {(DIFF_W-1){1'b1}}};
   localparam logic signed [DIFF_W-1:0] DIFF_MIN = {1'b1, {(DIFF_W-1){1'b0}}};

   // Chronological order codes
   typedef enum logic [1:0] {
      ORDER_BEFORE = 2'd0,
      ORDER_EQUAL  = 2'd1,
      ORDER_AFTER  = 2'd2
   } date_order_type;

   // Per-stage load enables of the pipeline
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   // Days before month m in a common year; months above twelve add 31 each
   function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [DBM_W-1:0] r;
      case (m)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         4'd13:   r = 9'd365;
         4'd14:   r = 9'd396;
         4'd15:   r = 9'd427;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Length of month m, leap decides February
   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
      logic [DAY_W-1:0] r;
      if (m == MONTH_W'(MONTH_APR) || m == MONTH_W'(MONTH_JUN) ||
          m == MONTH_W'(MONTH_SEP) || m == MONTH_W'(MONTH_NOV)) begin
         r = 5'd30;
      end else if (m == MONTH_W'(MONTH_FEB)) begin
         r = leap ? 5'd29 : 5'd28;
      end else begin
         r = 5'd31;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/dpd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for date pairs and difference results.
// Depends on dpd_pkg.
interface dpd_req_if;
   import dpd_pkg::*;

   logic               valid;
   logic               ready;
   logic [DAY_W-1:0]   start_day;
   logic [MONTH_W-1:0] start_month;
   logic [YEAR_W-1:0]  start_year;
   logic [DAY_W-1:0]   end_day;
   logic [MONTH_W-1:0] end_month;
   logic [YEAR_W-1:0]  end_year;

   modport source (output valid, start_day, start_month, start_year,
                   end_day, end_month, end_year, input ready);
   modport sink   (input valid, start_day, start_month, start_year,
                   end_day, end_month, end_year, output ready);
endinterface

interface dpd_rsp_if;
   import dpd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     start_valid;
   logic                     end_valid;
   logic signed [DIFF_W-1:0] day_difference;
   logic [1:0]               date_order;

   modport source (output valid, start_valid, end_valid, day_difference,
                   date_order, input ready);
   modport sink   (input valid, start_valid, end_valid, day_difference,
                   date_order, output ready);
endinterface

FILE: hw/rtl/dpd_date_serial.sv
`timescale 1ns / 1ps
// Three-stage datapath that turns one date into a serial day number and a
// validity flag. Depends on dpd_pkg.
module dpd_date_serial (
   input  logic                          clock,
   input  dpd_pkg::stage_en_type         en,
   input  logic [dpd_pkg::DAY_W-1:0]     day,
   input  logic [dpd_pkg::MONTH_W-1:0]   month,
   input  logic [dpd_pkg::YEAR_W-1:0]    year,
   output logic [dpd_pkg::SERIAL_W-1:0]  serial,
   output logic                          date_valid
);
   import dpd_pkg::*;

   // Stage 1: raw fields, earlier-year count p and both quotients by 100
   logic [YEAR_W-1:0]  p_in;
   logic [PROD_W-1:0]  prod_p, prod_y;
   logic [DAY_W-1:0]   d1_ff;
   logic [MONTH_W-1:0] m1_ff;
   logic [YEAR_W-1:0]  y1_ff, p1_ff;
   logic [QUOT_W-1:0]  qp1_ff, qy1_ff;

   assign p_in   = (year != '0) ? year - YEAR_W'(1) : '0;
   assign prod_p = PROD_W'(p_in) * PROD_W'(DIV100_MUL);
   assign prod_y = PROD_W'(year) * PROD_W'(DIV100_MUL);

   always_ff @(posedge clock) begin
      if (en.s1) begin
         d1_ff  <= day;
         m1_ff  <= month;
         y1_ff  <= year;
         p1_ff  <= p_in;
         qp1_ff <= prod_p[PROD_W-1 -: QUOT_W];
         qy1_ff <= prod_y[PROD_W-1 -: QUOT_W];
      end
   end

   // Stage 2: days of earlier years and the leap flag
   logic [SERIAL_W-1:0] years_in;
   logic [YEAR_W-1:0]   rem_in;
   logic                leap_in;
   logic [SERIAL_W-1:0] years2_ff;
   logic                leap2_ff, ynz2_ff;
   logic [DAY_W-1:0]    d2_ff;
   logic [MONTH_W-1:0]  m2_ff;

   assign years_in = SERIAL_W'(DAYS_PER_YEAR) * SERIAL_W'(p1_ff)
                   + SERIAL_W'(p1_ff >> 2)
                   - SERIAL_W'(qp1_ff)
                   + SERIAL_W'(qp1_ff >> 2);
   assign rem_in   = y1_ff - YEAR_W'(YEAR_W'(qy1_ff) * YEAR_W'(CENTURY));
   assign leap_in  = (rem_in == '0) ? (qy1_ff[1:0] == 2'd0) : (y1_ff[1:0] == 2'd0);

   always_ff @(posedge clock) begin
      if (en.s2) begin
         years2_ff <= years_in;
         leap2_ff  <= leap_in;
         ynz2_ff   <= (y1_ff != '0);
         d2_ff     <= d1_ff;
         m2_ff     <= m1_ff;
      end
   end

   // Stage 3: add month and day, check the date
   logic [SERIAL_W-1:0] serial_in;
   logic                feb_extra;
   logic                valid_in;
   logic [SERIAL_W-1:0] serial3_ff;
   logic                valid3_ff;

   assign feb_extra = leap2_ff && (m2_ff > MONTH_W'(MONTH_FEB));
   assign serial_in = years2_ff + SERIAL_W'(days_before_month(m2_ff))
                    + SERIAL_W'(feb_extra) + SERIAL_W'(d2_ff);
   assign valid_in  = ynz2_ff && (m2_ff != '0) && (m2_ff <= MONTH_W'(MONTH_DEC))
                   && (d2_ff != '0) && (d2_ff <= month_length(m2_ff, leap2_ff));

   always_ff @(posedge clock) begin
      if (en.s3) begin
         serial3_ff <= serial_in;
         valid3_ff  <= valid_in;
      end
   end

   assign serial     = serial3_ff;
   assign date_valid = valid3_ff;

endmodule

FILE: hw/rtl/dpd_diff.sv
`timescale 1ns / 1ps
// Output stage: signed difference of two serial day numbers, saturated to
// the result width. Depends on dpd_pkg.
module dpd_diff (
   input  logic                               clock,
   input  logic                               load,
   input  logic [dpd_pkg::SERIAL_W-1:0]       start_serial,
   input  logic [dpd_pkg::SERIAL_W-1:0]       end_serial,
   output logic signed [dpd_pkg::DIFF_W-1:0]  day_difference
);
   import dpd_pkg::*;

   logic signed [SERIAL_W:0]  wide_diff;
   logic signed [DIFF_W-1:0]  diff_in;
   logic signed [DIFF_W-1:0]  diff_ff;

   assign wide_diff = $signed({1'b0, end_serial}) - $signed({1'b0, start_serial});

   // Clamp when the top two bits disagree
   always_comb begin
      if (wide_diff[SERIAL_W] != wide_diff[SERIAL_W-1]) begin
         diff_in = wide_diff[SERIAL_W] ? DIFF_MIN : DIFF_MAX;
      end else begin
         diff_in = wide_diff[DIFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         diff_ff <= diff_in;
      end
   end

   assign day_difference = diff_ff;

endmodule

FILE: hw/rtl/date_pair_day_difference.sv
`timescale 1ns / 1ps
// Top level: day difference, validity and order of two Gregorian dates.
// Depends on dpd_pkg, dpd_if, dpd_date_serial and dpd_diff.
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+------------------------------------------
//   req_ch   | in  | valid/ready  | start/end day, month, year
//   rsp_ch   | out | valid/ready  | start_valid, end_valid, day_difference,
//            |     |              | date_order
//
// Four register stages: quotients, year days, serial numbers, difference.
// One date pair per cycle while the result channel does not stall.
// Reset clears the stage valid bits only.
// Each stage holds while it is full and the stage after it is stalled, so a
// stall backs up one stage at a time and bubbles are squeezed out.
module date_pair_day_difference (
   input  logic      clock,
   input  logic      reset,
   dpd_req_if.sink   req_ch,
   dpd_rsp_if.source rsp_ch
);
   import dpd_pkg::*;

   // Stage valid bits and load enables
   logic [3:0]   vld_ff;
   logic [3:0]   vld_in;
   stage_en_type en;

   assign en.s4 = !vld_ff[3] || rsp_ch.ready;
   assign en.s3 = !vld_ff[2] || en.s4;
   assign en.s2 = !vld_ff[1] || en.s3;
   assign en.s1 = !vld_ff[0] || en.s2;
   assign req_ch.ready = en.s1;

   // Advance valid bits where a stage loads, hold otherwise
   always_comb begin
      vld_in    = vld_ff;
      if (en.s1) vld_in[0] = req_ch.valid;
      if (en.s2) vld_in[1] = vld_ff[0];
      if (en.s3) vld_in[2] = vld_ff[1];
      if (en.s4) vld_in[3] = vld_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Order from the raw fields: year, then month, then day
   date_order_type order_in;
   date_order_type order1_ff, order2_ff, order3_ff, order4_ff;

   always_comb begin
      if (req_ch.start_year != req_ch.end_year) begin
         order_in = (req_ch.start_year < req_ch.end_year) ? ORDER_BEFORE : ORDER_AFTER;
      end else if (req_ch.start_month != req_ch.end_month) begin
         order_in = (req_ch.start_month < req_ch.end_month) ? ORDER_BEFORE : ORDER_AFTER;
      end else if (req_ch.start_day != req_ch.end_day) begin
         order_in = (req_ch.start_day < req_ch.end_day) ? ORDER_BEFORE : ORDER_AFTER;
      end else begin
         order_in = ORDER_EQUAL;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) order1_ff <= order_in;
      if (en.s2) order2_ff <= order1_ff;
      if (en.s3) order3_ff <= order2_ff;
      if (en.s4) order4_ff <= order3_ff;
   end

   // Serial day numbers of both dates
   logic [SERIAL_W-1:0] start_serial, end_serial;
   logic                start_ok, end_ok;

   dpd_date_serial u_start (
      .clock      (clock),
      .en         (en),
      .day        (req_ch.start_day),
      .month      (req_ch.start_month),
      .year       (req_ch.start_year),
      .serial     (start_serial),
      .date_valid (start_ok)
   );

   dpd_date_serial u_end (
      .clock      (clock),
      .en         (en),
      .day        (req_ch.end_day),
      .month      (req_ch.end_month),
      .year       (req_ch.end_year),
      .serial     (end_serial),
      .date_valid (end_ok)
   );

   // Output stage
   logic signed [DIFF_W-1:0] diff;
   logic                     start_ok4_ff, end_ok4_ff;

   dpd_diff u_diff (
      .clock          (clock),
      .load           (en.s4),
      .start_serial   (start_serial),
      .end_serial     (end_serial),
      .day_difference (diff)
   );

   always_ff @(posedge clock) begin
      if (en.s4) begin
         start_ok4_ff <= start_ok;
         end_ok4_ff   <= end_ok;
      end
   end

   assign rsp_ch.valid          = vld_ff[3];
   assign rsp_ch.start_valid    = start_ok4_ff;
   assign rsp_ch.end_valid      = end_ok4_ff;
   assign rsp_ch.day_difference = diff;
   assign rsp_ch.date_order     = order4_ff;

   // A transfer in always fills the first stage
   a_fill_first: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> vld_ff[0])
      else $error("accepted date pair did not enter the first stage");

   // Identical dates give no difference and equal validity
   a_equal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.date_order == ORDER_EQUAL |->
         rsp_ch.day_difference == '0 && rsp_ch.start_valid == rsp_ch.end_valid)
      else $error("equal dates with nonzero difference");

   // For real dates the order and the sign of the difference agree
   a_sign_before: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.start_valid && rsp_ch.end_valid &&
      rsp_ch.date_order == ORDER_BEFORE |-> rsp_ch.day_difference > 0)
      else $error("start before end but difference not positive");

   a_sign_after: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.start_valid && rsp_ch.end_valid &&
      rsp_ch.date_order == ORDER_AFTER |-> rsp_ch.day_difference < 0)
      else $error("start after end but difference not negative");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Testbench for date_pair_day_difference: drives date pairs, predicts validity,
// day span and order of each pair, and checks every result in order.
// Depends on dpd_pkg, dpd_if and the date_pair_day_difference top level.
module tb;
   import dpd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_PAIRS = 270;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } calendar_date_type;

   typedef struct packed {
      logic                     start_ok;
      logic                     end_ok;
      logic signed [DIFF_W-1:0] days;
      date_order_type           chrono;
   } day_span_type;

   logic clock;
   logic reset;

   dpd_req_if req_ch ();
   dpd_rsp_if rsp_ch ();

   date_pair_day_difference i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   day_span_type expected_spans[$];
   int        error_count    = 0;
   int        pairs_sent     = 0;
   int        results_checked = 0;
   int        both_real      = 0;
   int        clamped_spans  = 0;
   int        cycle_count    = 0;
   int        send_idle_pct  = 0;
   int        recv_idle_pct  = 0;

   // Clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Calendar arithmetic
   // ------------------------------------------------------------------
   function automatic logic leap_year(input logic [YEAR_W-1:0] y);
      return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
   endfunction

   // Months past December count as 31-day months
   function automatic int days_in_month(input int m, input logic leap);
      case (m)
         4, 6, 9, 11: return 30;
         2:           return leap ? 29 : 28;
         default:     return 31;
      endcase
   endfunction

   function automatic logic real_date(input calendar_date_type d);
      if (d.year < 1 || d.month < 1 || d.month > 12 || d.day < 1)
         return 1'b0;
      return d.day <= days_in_month(d.month, leap_year(d.year));
   endfunction

   // Days since the calendar origin, computed from the raw fields
   function automatic longint day_number(input calendar_date_type d);
      longint total;
      longint p;
      total = d.day;
      if (d.year != 0) begin
         p = d.year - 1;
         total += 365 * p + p / 4 - p / 100 + p / 400;
      end
      for (int k = 1; k < d.month; k++)
         total += days_in_month(k, 1'b0);
      if (d.month > 2 && leap_year(d.year))
         total += 1;
      return total;
   endfunction

   function automatic day_span_type predict_span(input calendar_date_type s,
                                                 input calendar_date_type e);
      day_span_type res;
      longint    span;
      longint    hi;
      longint    lo;
      hi   = DIFF_MAX;
      lo   = DIFF_MIN;
      span = day_number(e) - day_number(s);
      if (span > hi) span = hi;
      if (span < lo) span = lo;
      res.start_ok = real_date(s);
      res.end_ok   = real_date(e);
      res.days     = DIFF_W'(span);
      // Packed field order makes this a year, month, day comparison
      if (s < e)       res.chrono = ORDER_BEFORE;
      else if (s == e) res.chrono = ORDER_EQUAL;
      else             res.chrono = ORDER_AFTER;
      return res;
   endfunction

   function automatic calendar_date_type make_date(input int d, input int m, input int y);
      calendar_date_type r;
      r.day   = DAY_W'(d);
      r.month = MONTH_W'(m);
      r.year  = YEAR_W'(y);
      return r;
   endfunction

   function automatic calendar_date_type random_real_date();
      int y;
      int m;
      y = $urandom_range(9999, 1);
      m = $urandom_range(12, 1);
      return make_date($urandom_range(days_in_month(m, leap_year(YEAR_W'(y))), 1), m, y);
   endfunction

   // Raw fields; now and then the full 14-bit year range and year zero
   function automatic calendar_date_type random_raw_date();
      int y;
      case ($urandom_range(7))
         0:       y = $urandom_range(16383);
         1:       y = 0;
         default: y = $urandom_range(9999);
      endcase
      return make_date($urandom_range(31), $urandom_range(15), y);
   endfunction

   // ------------------------------------------------------------------
   // Mismatch reporting
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Present one pair after a random gap and hold it until the transfer
   task automatic send_pair(input calendar_date_type s, input calendar_date_type e);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid       <= 1'b1;
      req_ch.start_day   <= s.day;
      req_ch.start_month <= s.month;
      req_ch.start_year  <= s.year;
      req_ch.end_day     <= e.day;
      req_ch.end_month   <= e.month;
      req_ch.end_year    <= e.year;
      do @(posedge clock); while (!req_ch.ready);
      expected_spans.push_back(predict_span(s, e));
      pairs_sent++;
   endtask

   // Drop valid and hold off until every outstanding result has come back
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (expected_spans.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Result side: random stalls, in-order check of every transfer
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      day_span_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_spans.size() == 0) begin
               report_mismatch("result with no pair outstanding");
            end else begin
               want = expected_spans.pop_front();
               results_checked++;
               if (want.start_ok && want.end_ok) both_real++;
               if (want.days == DIFF_MAX || want.days == DIFF_MIN) clamped_spans++;
               if (rsp_ch.start_valid !== want.start_ok)
                  report_mismatch($sformatf("start_valid got %b want %b",
                                            rsp_ch.start_valid, want.start_ok));
               if (rsp_ch.end_valid !== want.end_ok)
                  report_mismatch($sformatf("end_valid got %b want %b",
                                            rsp_ch.end_valid, want.end_ok));
               if (rsp_ch.day_difference !== want.days)
                  report_mismatch($sformatf("day_difference got %0d want %0d",
                                            rsp_ch.day_difference, want.days));
               if (rsp_ch.date_order !== want.chrono)
                  report_mismatch($sformatf("date_order got %0d want %s",
                                            rsp_ch.date_order, want.chrono.name()));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Field extremes, calendar corner cases and the raw-field rules
   task automatic test_directed_cases();
      send_pair(make_date(0, 0, 0), make_date(0, 0, 0));
      send_pair(make_date(31, 15, 16383), make_date(31, 15, 16383));
      send_pair(make_date(1, 1, 1), make_date(31, 12, 9999));
      send_pair(make_date(31, 12, 9999), make_date(1, 1, 1));
      // clamp the span at both ends
      send_pair(make_date(0, 0, 0), make_date(31, 15, 16383));
      send_pair(make_date(31, 15, 16383), make_date(0, 0, 0));
      // leap rules: every 400th, not every 100th, every 4th
      send_pair(make_date(28, 2, 2000), make_date(29, 2, 2000));
      send_pair(make_date(29, 2, 1900), make_date(1, 3, 1900));
      send_pair(make_date(29, 2, 2004), make_date(29, 2, 2001));
      send_pair(make_date(31, 2, 2023), make_date(28, 2, 2023));
      // month length bounds
      send_pair(make_date(30, 4, 2023), make_date(31, 4, 2023));
      send_pair(make_date(30, 6, 500), make_date(1, 7, 500));
      send_pair(make_date(31, 12, 1999), make_date(1, 1, 2000));
      // day zero and month zero
      send_pair(make_date(0, 5, 2020), make_date(1, 5, 2020));
      send_pair(make_date(15, 0, 2020), make_date(15, 1, 2020));
      // months past December
      send_pair(make_date(1, 13, 2020), make_date(1, 14, 2020));
      send_pair(make_date(1, 15, 2020), make_date(31, 12, 2020));
      // year zero counts as leap
      send_pair(make_date(1, 3, 0), make_date(1, 3, 1));
      send_pair(make_date(29, 2, 0), make_date(1, 1, 1));
      // same day number but different order, then equal dates and adjacent days
      send_pair(make_date(31, 1, 2024), make_date(0, 2, 2024));
      send_pair(make_date(1, 1, 1), make_date(1, 1, 1));
      send_pair(make_date(17, 9, 8191), make_date(16, 9, 8191));
   endtask

   // Mostly real dates with random content, some close or equal pairs, some noise
   task automatic test_random_pairs(input int count);
      calendar_date_type s;
      calendar_date_type e;
      for (int n = 0; n < count; n++) begin
         s = random_real_date();
         case ($urandom_range(9))
            0, 1, 2, 3, 4: e = random_real_date();
            5, 6: begin
               e = s;
               e.day = DAY_W'($urandom_range(days_in_month(s.month, leap_year(s.year)), 1));
            end
            7: begin
               e = s;
               e.year = YEAR_W'($urandom_range(s.year + 1 > 9999 ? 9999 : s.year + 1,
                                               s.year - 1 < 1 ? 1 : s.year - 1));
            end
            8: e = s;
            default: begin
               s = random_raw_date();
               e = random_raw_date();
            end
         endcase
         if ($urandom_range(1)) send_pair(s, e);
         else                   send_pair(e, s);
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.start_day    <= '0;
      req_ch.start_month  <= '0;
      req_ch.start_year   <= '0;
      req_ch.end_day      <= '0;
      req_ch.end_month    <= '0;
      req_ch.end_year     <= '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      wait_for_results();

      send_idle_pct = 35;
      recv_idle_pct = 49;
      test_random_pairs(RANDOM_PAIRS);
      wait_for_results();

      send_idle_pct = 49;
      recv_idle_pct = 35;
      test_random_pairs(RANDOM_PAIRS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_pairs(RANDOM_PAIRS);
      wait_for_results();

      // let any stray result show up
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_spans.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_spans.size()));

      $display("tb: %0d date pairs sent, %0d results checked, %0d mismatches",
               pairs_sent, results_checked, error_count);
      $display("tb: %0d pairs of real dates, %0d clamped spans, three stall profiles",
               both_real, clamped_spans);
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
